// ===== src/aabbc_pkg.sv =====
package aabbc_pkg;

    // Default coordinate width; values use only the low COORD_BITS of each word.
    localparam int COORD_BITS_DEF = 32;

    // Quotient steps of the mass share divider after the leading bit.
    localparam int DIV_STEPS = 16;

    // Stage order: decode, edge select, divider steps, dot, multiply, apply.
    localparam int ST_DECODE = 0;
    localparam int ST_SELECT = 1;
    localparam int ST_DIV0   = 2;
    localparam int ST_DOT    = ST_DIV0 + DIV_STEPS;
    localparam int ST_MUL    = ST_DOT + 1;
    localparam int ST_APPLY  = ST_MUL + 1;
    localparam int NUM_STAGES = ST_APPLY + 1;

    // Mass share used when both masses are zero (one half in Q0.16).
    localparam logic [16:0] SHARE_HALF = 17'd32768;

    // One pair in flight; fields are filled in as the pair moves down the pipe.
    typedef struct packed {
        logic               hit;
        logic               trig_a;
        logic               b_static;
        logic signed [31:0] cp_x;
        logic signed [31:0] cp_y;
        logic signed [31:0] va_x;
        logic signed [31:0] va_y;
        logic signed [31:0] vb_x;
        logic signed [31:0] vb_y;
        logic signed [36:0] dd0;
        logic signed [36:0] dd1;
        logic signed [36:0] dd2;
        logic signed [36:0] dd3;
        logic [1:0]         dir;
        logic [30:0]        ov;
        logic [31:0]        ma;
        logic [32:0]        tot;
        logic [33:0]        rem;
        logic [16:0]        q;
        logic               dot_pos;
        logic [32:0]        dot;
        logic [16:0]        r16;
        logic [32:0]        part_b;
        logic [31:0]        sov;
        logic [63:0]        cp_o;
        logic [63:0]        nva;
        logic [63:0]        nvb;
        logic [63:0]        sha;
        logic [63:0]        shb;
    } pipe_t;

endpackage

// ===== src/aabb_pair_contact_resolve.sv =====
// Throughput: one request per cycle while the output is not stalled; each stage holds one pair and moves on its own.
// The mass share divider resolves one quotient bit per stage over 17 stages.
// A stalled output holds its result; empty stages upstream still fill.
// Reset (rst_n low, asynchronous) clears all stage valid bits; data is not reset.
module aabb_pair_contact_resolve
    import aabbc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] center_a,
    input  logic [63:0] size_a,
    input  logic [63:0] center_b,
    input  logic [63:0] size_b,
    input  logic [63:0] velocity_a,
    input  logic [63:0] velocity_b,
    input  logic [31:0] mass_a,
    input  logic [31:0] mass_b,
    input  logic        b_is_static,
    input  logic [1:0]  trigger_flags,
    input  logic [31:0] layers_a,
    input  logic [31:0] layers_b,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        collided,
    output logic [63:0] contact_point,
    output logic [1:0]  normal_dir,
    output logic [30:0] overlap,
    output logic [63:0] new_velocity_a,
    output logic [63:0] new_velocity_b,
    output logic [63:0] shift_a,
    output logic [63:0] shift_b
);

    localparam logic signed [36:0] SAT_HI = 37'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [36:0] SAT_LO = -SAT_HI - 37'sd1;
    localparam logic signed [36:0] OV_MAX = 37'sd2147483647;

    pipe_t                 p_reg [NUM_STAGES];
    pipe_t                 p_next [NUM_STAGES];
    logic [NUM_STAGES-1:0] v_reg;
    logic [NUM_STAGES-1:0] en;

    pipe_t st_a;
    pipe_t st_b;
    pipe_t st_d;
    pipe_t st_e;
    pipe_t st_f;

    // Sign-extend the low COORD_BITS of a word.
    function automatic logic signed [33:0] sext(input logic [31:0] w);
        logic signed [COORD_BITS-1:0] t;
        t = w[COORD_BITS-1:0];
        return 34'(t);
    endfunction

    // Zero-extend the low COORD_BITS of a word.
    function automatic logic signed [33:0] zext(input logic [31:0] w);
        logic [COORD_BITS-1:0] t;
        t = w[COORD_BITS-1:0];
        return 34'(t);
    endfunction

    // Clamp to the signed COORD_BITS range, sign-extended to a word.
    function automatic logic [31:0] sat(input logic signed [36:0] x);
        logic signed [36:0] c;
        c = x;
        if (c > SAT_HI)
            c = SAT_HI;
        if (c < SAT_LO)
            c = SAT_LO;
        return c[31:0];
    endfunction

    // Decode: filter the pair, form the doubled edge distances and the midpoint.
    always_comb
    begin
        logic signed [33:0] cax, cay, cbx, cby, sax, say, sbx, sby;
        logic signed [36:0] s0, s1, t0, t1;
        logic signed [33:0] sumx, sumy;
        logic               pass;
        cax = sext(center_a[31:0]);
        cay = sext(center_a[63:32]);
        cbx = sext(center_b[31:0]);
        cby = sext(center_b[63:32]);
        sax = zext(size_a[31:0]);
        say = zext(size_a[63:32]);
        sbx = zext(size_b[31:0]);
        sby = zext(size_b[63:32]);
        s0 = 37'(sax) + 37'(sbx);
        s1 = 37'(say) + 37'(sby);
        t0 = (37'(cbx) - 37'(cax)) <<< 1;
        t1 = (37'(cby) - 37'(cay)) <<< 1;
        sumx = cax + cbx;
        sumy = cay + cby;
        pass = !(trigger_flags[0] && trigger_flags[1]) && ((layers_a & layers_b) != 32'd0);
        st_a = '0;
        st_a.dd0 = s0 - t0;
        st_a.dd1 = s1 - t1;
        st_a.dd2 = s0 + t0;
        st_a.dd3 = s1 + t1;
        st_a.hit = pass && (st_a.dd0 > 0) && (st_a.dd1 > 0) && (st_a.dd2 > 0)
                   && (st_a.dd3 > 0);
        st_a.trig_a   = trigger_flags[0];
        st_a.b_static = b_is_static;
        st_a.cp_x = st_a.hit ? 32'(sumx >>> 1) : 32'sd0;
        st_a.cp_y = st_a.hit ? 32'(sumy >>> 1) : 32'sd0;
        st_a.va_x = 32'(sext(velocity_a[31:0]));
        st_a.va_y = 32'(sext(velocity_a[63:32]));
        st_a.vb_x = 32'(sext(velocity_b[31:0]));
        st_a.vb_y = 32'(sext(velocity_b[63:32]));
        st_a.ma   = mass_a;
        st_a.tot  = 33'(mass_a) + 33'(mass_b);
    end

    // Edge select: smallest edge distance (lowest index on ties) and the divider's leading bit.
    always_comb
    begin
        logic signed [36:0] dmin;
        logic signed [36:0] half;
        st_b = p_reg[ST_DECODE];
        dmin = st_b.dd0;
        st_b.dir = 2'd0;
        if (st_b.dd1 < dmin)
        begin
            dmin = st_b.dd1;
            st_b.dir = 2'd1;
        end
        if (st_b.dd2 < dmin)
        begin
            dmin = st_b.dd2;
            st_b.dir = 2'd2;
        end
        if (st_b.dd3 < dmin)
        begin
            dmin = st_b.dd3;
            st_b.dir = 2'd3;
        end
        half = dmin >>> 1;
        st_b.ov = (half > OV_MAX) ? 31'h7fffffff : half[30:0];
        if (!st_b.hit)
        begin
            st_b.dir = 2'd0;
            st_b.ov  = 31'd0;
        end
        if (33'(st_b.ma) >= st_b.tot)
        begin
            st_b.q   = 17'd1;
            st_b.rem = 34'(33'(st_b.ma) - st_b.tot);
        end
        else
        begin
            st_b.q   = 17'd0;
            st_b.rem = 34'(st_b.ma);
        end
    end

    // Divider steps, one quotient bit per stage.
    for (genvar g = 0; g < DIV_STEPS; g++)
    begin : g_div
        aabbc_div_step u_step (
            .stage_in  (p_reg[ST_DIV0 + g - 1]),
            .stage_out (p_next[ST_DIV0 + g])
        );
    end

    // Final share and the approach speed along the normal.
    always_comb
    begin
        logic signed [33:0] vak, vbk, diff, dotv;
        st_d = p_reg[ST_DOT - 1];
        if (st_d.b_static)
            st_d.r16 = 17'd0;
        else if (st_d.tot == 33'd0)
            st_d.r16 = SHARE_HALF;
        else
            st_d.r16 = st_d.q;
        vak  = st_d.dir[0] ? 34'(st_d.va_y) : 34'(st_d.va_x);
        vbk  = st_d.dir[0] ? 34'(st_d.vb_y) : 34'(st_d.vb_x);
        diff = st_d.b_static ? vak : (vak - vbk);
        dotv = st_d.dir[1] ? -diff : diff;
        st_d.dot_pos = dotv > 0;
        st_d.dot     = dotv[32:0];
    end

    // Split the approach speed and the overlap by the mass share.
    always_comb
    begin
        logic [49:0] pb;
        logic [47:0] ps;
        st_e = p_reg[ST_DOT];
        pb = 50'(st_e.r16) * 50'(st_e.dot);
        ps = 48'(st_e.r16) * 48'(st_e.ov);
        st_e.part_b = pb[48:16];
        st_e.sov    = ps[47:16];
    end

    // Apply corrections along the normal axis, saturate and pack.
    always_comb
    begin
        logic signed [36:0] vax, vay, vbx, vby, sax, say, sbx, sby;
        logic signed [36:0] da, db, sa, sb;
        logic               active;
        st_f = p_reg[ST_MUL];
        vax = 37'(st_f.va_x);
        vay = 37'(st_f.va_y);
        vbx = 37'(st_f.vb_x);
        vby = 37'(st_f.vb_y);
        sax = '0;
        say = '0;
        sbx = '0;
        sby = '0;
        active = st_f.hit && !st_f.trig_a;
        da = 37'(st_f.dot) - 37'(st_f.part_b);
        db = 37'(st_f.part_b);
        sa = 37'(st_f.ov) - 37'(st_f.sov);
        sb = 37'(st_f.sov);
        if (st_f.dir[1])
        begin
            da = -da;
            db = -db;
            sb = -sb;
        end
        else
        begin
            sa = -sa;
        end
        if (active)
        begin
            if (st_f.dot_pos)
            begin
                if (st_f.dir[0])
                    vay = vay - da;
                else
                    vax = vax - da;
                if (!st_f.b_static)
                begin
                    if (st_f.dir[0])
                        vby = vby + db;
                    else
                        vbx = vbx + db;
                end
            end
            if (st_f.dir[0])
                say = sa;
            else
                sax = sa;
            if (!st_f.b_static)
            begin
                if (st_f.dir[0])
                    sby = sb;
                else
                    sbx = sb;
            end
        end
        st_f.cp_o = {st_f.cp_y, st_f.cp_x};
        st_f.nva  = {sat(vay), sat(vax)};
        st_f.nvb  = {sat(vby), sat(vbx)};
        st_f.sha  = {sat(say), sat(sax)};
        st_f.shb  = {sat(sby), sat(sbx)};
    end

    assign p_next[ST_DECODE] = st_a;
    assign p_next[ST_SELECT] = st_b;
    assign p_next[ST_DOT]    = st_d;
    assign p_next[ST_MUL]    = st_e;
    assign p_next[ST_APPLY]  = st_f;

    // A stage loads when it is empty or when the stage after it moves.
    always_comb
    begin
        en[NUM_STAGES-1] = !v_reg[NUM_STAGES-1] || !out_stall;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
            en[i] = !v_reg[i] || en[i+1];
    end

    assign in_stall = !en[0];

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
                v_reg[0] <= in_valid;
            for (int i = 1; i < NUM_STAGES; i++)
                if (en[i])
                    v_reg[i] <= v_reg[i-1];
        end
    end

    // Stage data.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_STAGES; i++)
            if (en[i])
                p_reg[i] <= p_next[i];
    end

    // Output register is the last stage.
    assign out_valid      = v_reg[NUM_STAGES-1];
    assign collided       = p_reg[NUM_STAGES-1].hit;
    assign contact_point  = p_reg[NUM_STAGES-1].cp_o;
    assign normal_dir     = p_reg[NUM_STAGES-1].dir;
    assign overlap        = p_reg[NUM_STAGES-1].ov;
    assign new_velocity_a = p_reg[NUM_STAGES-1].nva;
    assign new_velocity_b = p_reg[NUM_STAGES-1].nvb;
    assign shift_a        = p_reg[NUM_STAGES-1].sha;
    assign shift_b        = p_reg[NUM_STAGES-1].shb;

    // The input stalls only when every stage is full and the output is held.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall && (&v_reg)))
        else $error("input stalled while the pipe has room");

    // A pair that misses reports no overlap, no contact point and no push-out.
    a_miss_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !collided) |-> (overlap == 31'd0 && shift_a == 64'd0
            && shift_b == 64'd0 && contact_point == 64'd0))
        else $error("push-out reported for a pair that did not collide");

    // A static B is never moved.
    a_static_b: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && p_reg[NUM_STAGES-1].b_static) |-> (shift_b == 64'd0))
        else $error("static box given a push-out");

endmodule

// ===== src/aabbc_div_step.sv =====
module aabbc_div_step
    import aabbc_pkg::*;
(
    input  pipe_t stage_in,
    output pipe_t stage_out
);

    logic [33:0] rem2;

    // One restoring step: shift the remainder and subtract the total mass if it fits.
    always_comb
    begin
        stage_out = stage_in;
        rem2 = {stage_in.rem[32:0], 1'b0};
        if (rem2 >= 34'(stage_in.tot))
        begin
            stage_out.rem = rem2 - 34'(stage_in.tot);
            stage_out.q   = {stage_in.q[15:0], 1'b1};
        end
        else
        begin
            stage_out.rem = rem2;
            stage_out.q   = {stage_in.q[15:0], 1'b0};
        end
    end

endmodule

// ===== verif/aabb_contact_checker.sv =====
module aabb_contact_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [63:0] center_a,
    input  logic [63:0] size_a,
    input  logic [63:0] center_b,
    input  logic [63:0] size_b,
    input  logic [63:0] velocity_a,
    input  logic [63:0] velocity_b,
    input  logic [31:0] mass_a,
    input  logic [31:0] mass_b,
    input  logic        b_is_static,
    input  logic [1:0]  trigger_flags,
    input  logic [31:0] layers_a,
    input  logic [31:0] layers_b,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        collided,
    input  logic [63:0] contact_point,
    input  logic [1:0]  normal_dir,
    input  logic [30:0] overlap,
    input  logic [63:0] new_velocity_a,
    input  logic [63:0] new_velocity_b,
    input  logic [63:0] shift_a,
    input  logic [63:0] shift_b,
    output int          fail_count,
    output int          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        hit;
        logic [63:0] cp;
        logic [1:0]  dir;
        logic [30:0] ov;
        logic [63:0] nva;
        logic [63:0] nvb;
        logic [63:0] sha;
        logic [63:0] shb;
    } contact_t;

    contact_t contact_q[$];

    // Clamp a wide signed value to the 32-bit word range.
    function automatic logic [31:0] clamp_word(longint x);
        if (x > 64'sd2147483647)
            return 32'h7fffffff;
        if (x < -64'sd2147483648)
            return 32'h80000000;
        return x[31:0];
    endfunction

    function automatic contact_t resolve_pair();
        longint ca[2], cb[2], sa[2], sb[2], va[2], vb[2];
        longint cp[2], sha[2], shb[2], dd[4];
        longint ov, s, sg, dot, part_b, sov, s0, s1, t0, t1;
        longint unsigned r16, tot;
        int dir, ax;
        logic hit, trig_a;
        contact_t r;
        cp = '{0, 0};
        sha = '{0, 0};
        shb = '{0, 0};
        hit = 0;
        dir = 0;
        ov = 0;
        trig_a = trigger_flags[0];
        for (int k = 0; k < 2; k++)
        begin
            ca[k] = longint'($signed(center_a[32*k +: 32]));
            cb[k] = longint'($signed(center_b[32*k +: 32]));
            va[k] = longint'($signed(velocity_a[32*k +: 32]));
            vb[k] = longint'($signed(velocity_b[32*k +: 32]));
            sa[k] = longint'({32'd0, size_a[32*k +: 32]});
            sb[k] = longint'({32'd0, size_b[32*k +: 32]});
        end
        // Layer and trigger filter, then the four doubled edge distances.
        if (!(trigger_flags == 2'b11) && ((layers_a & layers_b) != 0))
        begin
            s0 = sa[0] + sb[0];
            s1 = sa[1] + sb[1];
            t0 = 2 * (cb[0] - ca[0]);
            t1 = 2 * (cb[1] - ca[1]);
            dd[0] = s0 - t0;
            dd[1] = s1 - t1;
            dd[2] = s0 + t0;
            dd[3] = s1 + t1;
            hit = dd[0] > 0 && dd[1] > 0 && dd[2] > 0 && dd[3] > 0;
            if (hit)
            begin
                for (int i = 1; i < 4; i++)
                    if (dd[i] < dd[dir])
                        dir = i;
                ov = dd[dir] / 2;
                if (ov > 2147483647)
                    ov = 2147483647;
                for (int k = 0; k < 2; k++)
                begin
                    s = ca[k] + cb[k];
                    cp[k] = (s - (s & 1)) / 2;
                end
            end
        end
        // Velocity and push-out split by mass share.
        if (hit && !trig_a)
        begin
            ax = dir & 1;
            sg = (dir < 2) ? 1 : -1;
            tot = longint'(mass_a) + longint'(mass_b);
            if (b_is_static)
                r16 = 0;
            else if (tot == 0)
                r16 = 32768;
            else
                r16 = (longint'(mass_a) << 16) / tot;
            dot = b_is_static ? sg * va[ax] : sg * (va[ax] - vb[ax]);
            if (dot > 0)
            begin
                part_b = longint'((r16 * longint'(dot)) >> 16);
                va[ax] -= sg * (dot - part_b);
                if (!b_is_static)
                    vb[ax] += sg * part_b;
            end
            sov = longint'((r16 * longint'(ov)) >> 16);
            sha[ax] = -sg * (ov - sov);
            if (!b_is_static)
                shb[ax] = sg * sov;
        end
        r.hit = hit;
        r.cp = {clamp_word(cp[1]), clamp_word(cp[0])};
        r.dir = dir[1:0];
        r.ov = ov[30:0];
        r.nva = {clamp_word(va[1]), clamp_word(va[0])};
        r.nvb = {clamp_word(vb[1]), clamp_word(vb[0])};
        r.sha = {clamp_word(sha[1]), clamp_word(sha[0])};
        r.shb = {clamp_word(shb[1]), clamp_word(shb[0])};
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        pending_count = 0;
    end

    // Predict on each accepted request; compare each accepted result.
    always @(posedge clk)
    begin
        contact_t e;
        if (rst_n && in_valid && !in_stall)
            contact_q.push_back(resolve_pair());
        if (rst_n && out_valid && !out_stall)
        begin
            if (contact_q.size() == 0)
                report_mismatch("unexpected result", 0, 0);
            else
            begin
                e = contact_q.pop_front();
                if (collided !== e.hit)
                    report_mismatch("collided", collided, e.hit);
                if (contact_point !== e.cp)
                    report_mismatch("contact_point", contact_point, e.cp);
                if (normal_dir !== e.dir)
                    report_mismatch("normal_dir", normal_dir, e.dir);
                if (overlap !== e.ov)
                    report_mismatch("overlap", overlap, e.ov);
                if (new_velocity_a !== e.nva)
                    report_mismatch("new_velocity_a", new_velocity_a, e.nva);
                if (new_velocity_b !== e.nvb)
                    report_mismatch("new_velocity_b", new_velocity_b, e.nvb);
                if (shift_a !== e.sha)
                    report_mismatch("shift_a", shift_a, e.sha);
                if (shift_b !== e.shb)
                    report_mismatch("shift_b", shift_b, e.shb);
            end
        end
        pending_count = contact_q.size();
    end
endmodule

// ===== verif/tb_aabb_pair_contact_resolve.sv =====
module tb_aabb_pair_contact_resolve;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 21;
    localparam int NUM_RANDOM = 1250;
    localparam longint CYCLE_LIMIT = 400000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [63:0] center_a = 0, size_a = 0, center_b = 0, size_b = 0;
    logic [63:0] velocity_a = 0, velocity_b = 0;
    logic [31:0] mass_a = 0, mass_b = 0, layers_a = 0, layers_b = 0;
    logic        b_is_static = 0;
    logic [1:0]  trigger_flags = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic        collided;
    logic [63:0] contact_point;
    logic [1:0]  normal_dir;
    logic [30:0] overlap;
    logic [63:0] new_velocity_a, new_velocity_b, shift_a, shift_b;
    int          fail_count, pending_count;
    longint      cycles = 0;
    logic        hold_off = 0;

    always
    begin
        #4 clk = 1;
        #4 clk = 0;
    end

    aabb_pair_contact_resolve u_dut (.*);
    aabb_contact_checker u_check (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_aabb_pair_contact_resolve NOT OK");
            $finish;
        end
    end

    // Receiver stall pattern, with a long hold-off when requested.
    initial
    begin
        int mode;
        mode = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
                out_stall <= 1;
            else
            begin
                if ($urandom_range(0, 63) == 0)
                    mode = $urandom_range(0, 2);
                case (mode)
                    0: out_stall <= 0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    default: out_stall <= ($urandom_range(0, 1) == 0);
                endcase
            end
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom_range(0, 3) == 0 ? 32'h7fffffff : 32'h80000000;
            default: return $signed($urandom_range(0, 32'h000c0000)) - 32'sh00060000;
        endcase
    endfunction

    function automatic logic [31:0] rand_size();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'hffffffff : 32'h0;
            default: return $urandom_range(0, 32'h00080000);
        endcase
    endfunction

    function automatic logic [31:0] rand_mass();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return $urandom;
            2: return 32'hffffffff;
            default: return $urandom_range(0, 32'h00100000);
        endcase
    endfunction

    // Present one request and hold it until accepted.
    task automatic send_request(logic [63:0] ca, sa, cb, sb, va, vb,
                                logic [31:0] ma, mb, logic st, logic [1:0] tf,
                                logic [31:0] la, lb);
        center_a <= ca; size_a <= sa; center_b <= cb; size_b <= sb;
        velocity_a <= va; velocity_b <= vb; mass_a <= ma; mass_b <= mb;
        b_is_static <= st; trigger_flags <= tf; layers_a <= la; layers_b <= lb;
        in_valid <= 1;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_random();
        logic [1:0] tf;
        logic [31:0] la;
        la = $urandom;
        tf = ($urandom_range(0, 3) == 0) ? 2'($urandom) : 2'b00;
        send_request({rand_coord(), rand_coord()}, {rand_size(), rand_size()},
                     {rand_coord(), rand_coord()}, {rand_size(), rand_size()},
                     {rand_coord(), rand_coord()}, {rand_coord(), rand_coord()},
                     rand_mass(), rand_mass(), $urandom_range(0, 1), tf, la,
                     ($urandom_range(0, 7) == 0) ? $urandom : (la | 32'h1));
    endtask

    task automatic idle_gap();
        in_valid <= 0;
        repeat ($urandom_range(1, 6))
            @(posedge clk);
    endtask

    initial
    begin
        int burst;
        repeat (5)
            @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: overlaps on each side, ties, triggers, filters, mass extremes.
        send_request({32'd0, 32'd0}, {32'h00020000, 32'h00020000},
                     {32'd0, 32'h00008000}, {32'h00020000, 32'h00020000},
                     {32'd0, 32'h00010000}, 64'd0, 32'h00010000, 32'h00010000,
                     0, 2'b00, 32'h1, 32'h1);
        send_request({32'd0, 32'd0}, {32'h00020000, 32'h00020000},
                     {32'd0, 32'h00008000}, {32'h00020000, 32'h00020000},
                     {32'd0, 32'h00010000}, 64'd0, 0, 0, 0, 2'b00, 32'h1, 32'h1);
        send_request({32'd0, 32'd0}, {32'h00020000, 32'h00020000},
                     {32'hffff8000, 32'd0}, {32'h00020000, 32'h00020000},
                     {32'd0, 32'hffff0000}, 64'd0, 32'hffffffff, 0, 0, 2'b00, 32'h2, 32'h2);
        send_request({32'd0, 32'd0}, {32'h00020000, 32'h00020000},
                     {32'd0, 32'd0}, {32'h00020000, 32'h00020000},
                     64'h0001000000010000, 64'hffff0000ffff0000, 0, 32'hffffffff,
                     0, 2'b00, 32'hffffffff, 32'h80000000);
        send_request({32'd0, 32'd0}, {32'h00020000, 32'h00020000},
                     {32'h00008000, 32'd0}, {32'h00020000, 32'h00020000},
                     64'h0000000000010000, 64'd0, 32'h00010000, 32'h00010000,
                     1, 2'b00, 32'h1, 32'h1);
        for (int t = 0; t < 4; t++)
            send_request({32'd0, 32'd0}, {32'h00020000, 32'h00020000},
                         {32'h00004000, 32'hffffc000}, {32'h00020000, 32'h00020000},
                         64'h00010000ffff0000, 64'd0, 32'h00010000, 32'h00030000,
                         0, 2'(t), 32'h1, 32'h1);
        send_request({32'd0, 32'd0}, {32'h00020000, 32'h00020000},
                     {32'd0, 32'd0}, {32'h00020000, 32'h00020000},
                     64'd0, 64'd0, 0, 0, 0, 2'b00, 32'h0000ffff, 32'hffff0000);
        send_request({32'd0, 32'd0}, {32'h00010000, 32'h00010000},
                     {32'h00010000, 32'd0}, {32'h00010000, 32'h00010000},
                     64'd0, 64'd0, 0, 0, 0, 2'b00, 32'h1, 32'h1);
        send_request({32'h7fffffff, 32'h80000000}, 64'hffffffffffffffff,
                     {32'h80000000, 32'h7fffffff}, 64'hffffffffffffffff,
                     {32'h80000000, 32'h7fffffff}, {32'h7fffffff, 32'h80000000},
                     32'hffffffff, 32'hffffffff, 0, 2'b00, 32'hffffffff, 32'hffffffff);
        send_request(64'hffffffffffffffff, 64'hffffffffffffffff, 64'd0,
                     64'hffffffffffffffff, 64'h8000000080000000, 64'h7fffffff7fffffff,
                     0, 32'h1, 0, 2'b00, 32'h1, 32'h1);

        // Random bursts, with long receiver hold-offs near request 300 and drain pauses near request 700.
        for (int n = 0; n < NUM_RANDOM; )
        begin
            burst = $urandom_range(1, 20);
            for (int j = 0; j < burst && n < NUM_RANDOM; j++, n++)
                send_random();
            if (n > 300 && n < 330)
            begin
                hold_off <= 1;
                fork
                    begin
                        repeat (200)
                            @(posedge clk);
                        hold_off <= 0;
                    end
                join_none
            end
            if (n > 700 && n < 730)
            begin
                in_valid <= 0;
                wait (pending_count == 0);
                @(posedge clk);
            end
            if ($urandom_range(0, 2) != 0)
                idle_gap();
        end
        in_valid <= 0;

        wait (pending_count == 0 && !hold_off);
        repeat (LATENCY + 10)
            @(posedge clk);
        if (fail_count == 0)
            $display("tb_aabb_pair_contact_resolve OK");
        else
            $display("tb_aabb_pair_contact_resolve NOT OK");
        $finish;
    end
endmodule

// ===== aabb_pair_contact_resolve.f =====
src/aabbc_pkg.sv
src/aabbc_div_step.sv
src/aabb_pair_contact_resolve.sv
verif/aabb_contact_checker.sv
verif/tb_aabb_pair_contact_resolve.sv
